### design/rmsu_pkg.sv
`timescale 1ns / 1ps

package rmsu_pkg;

    localparam int BYTE_W = 8;

    // width of a stream data bus carrying w payload bits
    function automatic int bytes_up(input int w);
        return ((w + BYTE_W - 1) / BYTE_W) * BYTE_W;
    endfunction

endpackage

### design/rmsu_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, several lanes in lockstep
module rmsu_div #(
    parameter int N      = 65,
    parameter int D      = 17,
    parameter int LANES  = 3,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [N-1:0]      i_num [LANES],
    input  logic [D-1:0]      i_den [LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [N-1:0]      o_quo [LANES],
    output logic [D-1:0]      o_rem [LANES],
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [N];
    logic [SIDE_W-1:0] r_side [N];
    logic [N-1:0]      r_num  [N][LANES];
    logic [D-1:0]      r_rem  [N][LANES];
    logic [D-1:0]      r_den  [N][LANES];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              a_v;
        logic [SIDE_W-1:0] a_side;

        if (k == 0) begin : g_in
            assign a_v    = i_valid;
            assign a_side = i_side;
        end else begin : g_mid
            assign a_v    = r_v[k-1];
            assign a_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= a_side;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [N-1:0] a_num;
            logic [D-1:0] a_rem;
            logic [D-1:0] a_den;
            logic [D:0]   t;
            logic [D:0]   t_sub;
            logic         ge;

            if (k == 0) begin : g_in
                assign a_num = i_num[l];
                assign a_rem = '0;
                assign a_den = i_den[l];
            end else begin : g_mid
                assign a_num = r_num[k-1][l];
                assign a_rem = r_rem[k-1][l];
                assign a_den = r_den[k-1][l];
            end

            assign t     = {a_rem, a_num[N-1]};
            assign t_sub = t - {1'b0, a_den};
            assign ge    = (t >= {1'b0, a_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k][l] <= {a_num[N-2:0], ge};
                    r_rem[k][l] <= ge ? t_sub[D-1:0] : t[D-1:0];
                    r_den[k][l] <= a_den;
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_num[N-1][l];
        assign o_rem[l] = r_rem[N-1][l];
    end

    assign o_valid = r_v[N-1];
    assign o_side  = r_side[N-1];

endmodule

### design/rmsu_sqrt.sv
`timescale 1ns / 1ps

// digit-by-digit integer square root, one root bit per stage, rounded down
module rmsu_sqrt #(
    parameter int RW     = 32,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v    [RW];
    logic [SIDE_W-1:0] r_side [RW];
    logic [2*RW-1:0]   r_rad  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [RW+1:0]     r_rem  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              a_v;
        logic [SIDE_W-1:0] a_side;
        logic [2*RW-1:0]   a_rad;
        logic [RW-1:0]     a_root;
        logic [RW+1:0]     a_rem;
        logic [RW+1:0]     t;
        logic [RW+1:0]     trial;
        logic              ge;

        if (k == 0) begin : g_in
            assign a_v    = i_valid;
            assign a_side = i_side;
            assign a_rad  = i_rad;
            assign a_root = '0;
            assign a_rem  = '0;
        end else begin : g_mid
            assign a_v    = r_v[k-1];
            assign a_side = r_side[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_root = r_root[k-1];
            assign a_rem  = r_rem[k-1];
        end

        assign t     = {a_rem[RW-1:0], a_rad[2*RW-1:2*RW-2]};
        assign trial = {a_root, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= a_side;
                r_rad[k]  <= {a_rad[2*RW-3:0], 2'b00};
                r_root[k] <= {a_root[RW-2:0], ge};
                r_rem[k]  <= ge ? (t - trial) : t;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

### design/running_mean_sigma_update.sv
`timescale 1ns / 1ps

// channel   dir  fields (lowest bit first)
// s_axis    in   sample_value, prior_mean, prior_sigma, prior_count
// m_axis    out  tdata: updated_mean, updated_sigma; tuser: saturated
//
// One transfer in per cycle while the skid is empty. Stages: two input stages,
// a 2*DATA_WIDTH+1 stage divider, a correction stage, a DATA_WIDTH stage
// square root and the output register.
// A skid register behind the output lets the pipeline take one more result
// while the output is held; the whole pipeline freezes while the skid is full.
// Synchronous active-low reset clears all valid bits. Values are Q.16 fixed point.
module running_mean_sigma_update
    import rmsu_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16,
    localparam int IN_W  = bytes_up(3 * DATA_WIDTH - 1 + COUNT_WIDTH),
    localparam int OUT_W = bytes_up(2 * DATA_WIDTH - 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // sample_value, prior_mean, prior_sigma, prior_count
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // updated_mean, updated_sigma
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // saturated
    output logic             o_m_axis_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int NW     = 2 * DW + 1;
    localparam int DEN_W  = CW + 1;
    localparam int DSIDE  = 2 * DW - 2 + DW + 2;
    localparam int QSIDE  = DW + 2;
    localparam int RES_W  = 2 * DW;

    logic en;

    // input fields
    logic [DW-1:0]   in_x;
    logic [DW-1:0]   in_m;
    logic [DW-2:0]   in_s;
    logic [CW-1:0]   in_n;
    logic [DW:0]     d_full;
    logic [DW:0]     d_abs;
    logic            in_zero;

    assign in_x    = i_s_axis_tdata[DW-1:0];
    assign in_m    = i_s_axis_tdata[2*DW-1:DW];
    assign in_s    = i_s_axis_tdata[3*DW-2:2*DW];
    assign in_n    = i_s_axis_tdata[3*DW-2+CW:3*DW-1];
    assign in_zero = (in_n == '0);
    assign d_full  = {in_x[DW-1], in_x} - {in_m[DW-1], in_m};
    assign d_abs   = d_full[DW] ? (~d_full + 1'b1) : d_full;

    // stage 0
    logic          r0_v;
    logic          r0_zero;
    logic          r0_neg;
    logic [DW-1:0] r0_dmag;
    logic [DW-1:0] r0_m;
    logic [DW-2:0] r0_s;
    logic [CW-1:0] r0_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_zero <= in_zero;
            r0_neg  <= in_zero ? 1'b0 : d_full[DW];
            r0_dmag <= in_zero ? '0 : d_abs[DW-1:0];
            r0_m    <= in_zero ? in_x : in_m;
            r0_s    <= in_s;
            r0_n    <= in_n;
        end
    end

    // stage 1: squares
    logic            r1_v;
    logic            r1_zero;
    logic            r1_neg;
    logic [DW-1:0]   r1_dmag;
    logic [DW-1:0]   r1_m;
    logic [CW-1:0]   r1_n;
    logic [2*DW-3:0] r1_s2;
    logic [2*DW-1:0] r1_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_zero <= r0_zero;
            r1_neg  <= r0_neg;
            r1_dmag <= r0_dmag;
            r1_m    <= r0_m;
            r1_n    <= r0_n;
            r1_s2   <= r0_s * r0_s;
            r1_d2   <= r0_dmag * r0_dmag;
        end
    end

    // divider lanes: mean step, ceil(s^2/n), d^2/(n+1)
    logic [NW-1:0]    div_num [3];
    logic [DEN_W-1:0] div_den [3];
    logic [NW-1:0]    div_quo [3];
    logic [DEN_W-1:0] div_rem [3];
    logic [DSIDE-1:0] div_side_in;
    logic [DSIDE-1:0] div_side;
    logic             div_v;

    assign div_num[0]  = NW'(r1_dmag);
    assign div_den[0]  = DEN_W'(r1_n) + 1'b1;
    assign div_num[1]  = NW'(r1_s2) + NW'(r1_n) - 1'b1;
    assign div_den[1]  = DEN_W'(r1_n);
    assign div_num[2]  = NW'(r1_d2);
    assign div_den[2]  = DEN_W'(r1_n) + 1'b1;
    assign div_side_in = {r1_s2, r1_m, r1_neg, r1_zero};

    rmsu_div #(
        .N      (NW),
        .D      (DEN_W),
        .LANES  (3),
        .SIDE_W (DSIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_side  (div_side_in),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_side  (div_side)
    );

    // correction stage: mean and radicand
    logic            dv_zero;
    logic            dv_neg;
    logic [DW-1:0]   dv_m;
    logic [2*DW-3:0] dv_s2;
    logic            ra_nz;
    logic [DW:0]     qadj;
    logic [DW+1:0]   qs;
    logic [DW+1:0]   mean_w;
    logic [DW+1:0]   mean_f;
    logic            mean_ovf;
    logic [DW-1:0]   n_mean;
    logic [2*DW-3:0] term_a;
    logic [2*DW-1:0] n_rad;

    assign {dv_s2, dv_m, dv_neg, dv_zero} = div_side;
    assign ra_nz    = (div_rem[0] != '0);
    // floor of a negative step with a nonzero remainder is one below the truncated quotient
    assign qadj     = {1'b0, div_quo[0][DW-1:0]} + (ra_nz & dv_neg);
    assign qs       = dv_neg ? (~{1'b0, qadj} + 1'b1) : {1'b0, qadj};
    assign mean_w   = {{2{dv_m[DW-1]}}, dv_m} + qs;
    assign mean_f   = (ra_nz && mean_w[DW+1]) ? (mean_w + 1'b1) : mean_w;
    assign mean_ovf = !((mean_f[DW+1:DW-1] == 3'b000) || (mean_f[DW+1:DW-1] == 3'b111));
    assign n_mean   = mean_ovf ? {mean_f[DW+1], {(DW-1){~mean_f[DW+1]}}} : mean_f[DW-1:0];
    assign term_a   = dv_s2 - div_quo[1][2*DW-3:0];
    assign n_rad    = {2'b00, term_a} + {1'b0, div_quo[2][2*DW-2:0]};

    logic            r2_v;
    logic            r2_zero;
    logic            r2_sat;
    logic [DW-1:0]   r2_mean;
    logic [2*DW-1:0] r2_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_zero <= dv_zero;
            r2_sat  <= mean_ovf;
            r2_mean <= n_mean;
            r2_rad  <= n_rad;
        end
    end

    // square root
    logic [QSIDE-1:0] sq_side;
    logic             sq_v;
    logic [DW-1:0]    sq_root;

    rmsu_sqrt #(
        .RW     (DW),
        .SIDE_W (QSIDE)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_rad   (r2_rad),
        .i_side  ({r2_sat, r2_mean, r2_zero}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic            sq_zero;
    logic            sq_sat_m;
    logic [DW-1:0]   sq_mean;
    logic            sig_ovf;
    logic [DW-2:0]   fin_sigma;
    logic            fin_sat;
    logic [RES_W-1:0] fin_d;

    assign {sq_sat_m, sq_mean, sq_zero} = sq_side;
    assign sig_ovf   = sq_root[DW-1];
    assign fin_sigma = sq_zero ? '0 : (sig_ovf ? '1 : sq_root[DW-2:0]);
    assign fin_sat   = !sq_zero && (sq_sat_m || sig_ovf);
    assign fin_d     = {fin_sat, fin_sigma, sq_mean};

    // output register and skid
    logic             r_ov;
    logic             r_sv;
    logic [RES_W-1:0] r_od;
    logic [RES_W-1:0] r_sd;

    assign en = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_ov && !i_m_axis_tready) begin
            if (en && sq_v) begin
                r_sv <= 1'b1;
                r_sd <= fin_d;
            end
        end else if (r_sv) begin
            r_ov <= 1'b1;
            r_od <= r_sd;
            r_sv <= 1'b0;
        end else begin
            r_ov <= sq_v;
            r_od <= fin_d;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OUT_W'(r_od[RES_W-2:0]);
    assign o_m_axis_tuser  = r_od[RES_W-1];

endmodule
